// File: hw/rtl/wuf_pkg.sv
// ---------------------------------------------------------------------------
// wuf_pkg
// shared types and constants for the weighted union-find engine
// ---------------------------------------------------------------------------
package wuf_pkg;

  // width of a node index field on the ports
  localparam int NODE_W = 10;

  // counter width for the index reduction steps (at most NODE_W steps)
  localparam int RED_CNT_W = 4;

  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } wuf_in_t;

  typedef struct packed {
    logic connected;
    logic merged;
  } wuf_out_t;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_JOIN  = 1'b1;

  // memory read address source
  typedef enum logic [1:0] {
    RD_PARENT = 2'd0,
    RD_NODE_A = 2'd1,
    RD_NODE_B = 2'd2
  } wuf_rd_sel_t;

  // memory write source
  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CLEAR = 2'd1,
    WR_CHILD = 2'd2,
    WR_ROOT  = 2'd3
  } wuf_wr_sel_t;

  typedef struct packed {
    logic        load_in;
    logic        reduce;
    wuf_rd_sel_t rd_sel;
    logic        cap_a;
    logic        cap_b;
    wuf_wr_sel_t wr_sel;
    logic        clr_step;
    logic        load_out;
  } wuf_cmd_t;

  typedef struct packed {
    logic red_done;
    logic at_root;
    logic merge;
    logic clr_last;
  } wuf_sts_t;

endpackage

// File: hw/rtl/wuf_dp.sv
// ---------------------------------------------------------------------------
// wuf_dp
// datapath: index reduction, node memory, root walk registers, link logic
// ---------------------------------------------------------------------------
module wuf_dp #(
  parameter int NODES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wuf_pkg::wuf_cmd_t cmd,
  output wuf_pkg::wuf_sts_t sts,
  input  wuf_pkg::wuf_in_t  in_data,
  output wuf_pkg::wuf_out_t out_data
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW = $clog2(NODES + 1);
  localparam int MW = SW + IW;
  localparam int FIELD_MAX = (1 << wuf_pkg::NODE_W) - 1;
  // binary reduction steps needed to bring a field value below NODES
  localparam int RED_STEPS = (NODES > FIELD_MAX) ? 0 : $clog2(FIELD_MAX / NODES + 1);

  logic                          op_r;
  logic [wuf_pkg::NODE_W-1:0]    a_r, a_nxt;
  logic [wuf_pkg::NODE_W-1:0]    b_r, b_nxt;
  logic [wuf_pkg::RED_CNT_W-1:0] red_cnt_r;
  logic [wuf_pkg::RED_CNT_W-1:0] red_shift;
  logic [31:0]                   step_val;

  logic [MW-1:0] mem [NODES];
  logic [MW-1:0] rdata_r;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] cur_r;
  logic [IW-1:0] rd_parent;
  logic [SW-1:0] rd_size;

  logic [IW-1:0] root_a_r, root_b_r;
  logic [SW-1:0] size_a_r, size_b_r;
  logic [IW-1:0] clr_cnt_r;

  logic          a_big;
  logic [IW-1:0] child_idx, surv_idx;
  logic [SW-1:0] child_size, sum_size;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic          same;

  wuf_pkg::wuf_out_t out_r;

  // one shift-subtract step of the modulo per cycle
  assign red_shift = red_cnt_r - wuf_pkg::RED_CNT_W'(1);
  assign step_val  = 32'(NODES) << red_shift;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (32'(a_r) >= step_val) a_nxt = a_r - wuf_pkg::NODE_W'(step_val);
    if (32'(b_r) >= step_val) b_nxt = b_r - wuf_pkg::NODE_W'(step_val);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= in_data.operation;
      a_r       <= in_data.node_a;
      b_r       <= in_data.node_b;
      red_cnt_r <= wuf_pkg::RED_CNT_W'(RED_STEPS);
    end else if (cmd.reduce && red_cnt_r != '0) begin
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      red_cnt_r <= red_shift;
    end
  end

  assign rd_parent = rdata_r[IW-1:0];
  assign rd_size   = rdata_r[MW-1:IW];

  always_comb begin
    unique case (cmd.rd_sel)
      wuf_pkg::RD_NODE_A: rd_addr = IW'(a_r);
      wuf_pkg::RD_NODE_B: rd_addr = IW'(b_r);
      default:            rd_addr = rd_parent;
    endcase
  end

  // link choice: smaller tree goes under the larger, ties put a under b
  assign a_big      = size_a_r > size_b_r;
  assign child_idx  = a_big ? root_b_r : root_a_r;
  assign surv_idx   = a_big ? root_a_r : root_b_r;
  assign child_size = a_big ? size_b_r : size_a_r;
  assign sum_size   = size_a_r + size_b_r;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = clr_cnt_r;
    wr_data = {SW'(1), clr_cnt_r};
    unique case (cmd.wr_sel)
      wuf_pkg::WR_CLEAR: begin
        wr_addr = clr_cnt_r;
        wr_data = {SW'(1), clr_cnt_r};
      end
      wuf_pkg::WR_CHILD: begin
        wr_addr = child_idx;
        wr_data = {child_size, surv_idx};
      end
      wuf_pkg::WR_ROOT: begin
        wr_addr = surv_idx;
        wr_data = {sum_size, surv_idx};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
    cur_r   <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      root_a_r <= cur_r;
      size_a_r <= rd_size;
    end
    if (cmd.cap_b) begin
      root_b_r <= cur_r;
      size_b_r <= rd_size;
    end
  end

  assign same = root_a_r == root_b_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.connected <= same;
      out_r.merged    <= (op_r == wuf_pkg::OP_JOIN) && !same;
    end
  end

  assign out_data     = out_r;
  assign sts.red_done = red_cnt_r == '0;
  assign sts.at_root  = rd_parent == cur_r;
  assign sts.merge    = (op_r == wuf_pkg::OP_JOIN) && !same;
  assign sts.clr_last = clr_cnt_r == IW'(NODES - 1);

  a_child_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sel == wuf_pkg::WR_CHILD |-> child_idx != surv_idx)
    else $error("link would point a root at itself");

  a_index_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_sel == wuf_pkg::RD_NODE_A |-> (32'(a_r) < 32'(NODES) && 32'(b_r) < 32'(NODES)))
    else $error("walk started on an unreduced node index");

endmodule

// File: hw/rtl/wuf_ctrl.sv
// ---------------------------------------------------------------------------
// wuf_ctrl
// sequencer for clear pass, root walks, linking and result hand-off
// ---------------------------------------------------------------------------
module wuf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output wuf_pkg::wuf_cmd_t cmd,
  input  wuf_pkg::wuf_sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_WALK_A,
    ST_WALK_B,
    ST_DECIDE,
    ST_LINK_ROOT,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept = in_valid && !in_stall_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = wuf_pkg::RD_PARENT;
    cmd.wr_sel   = wuf_pkg::WR_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_sel   = wuf_pkg::WR_CLEAR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (sts.red_done) begin
          cmd.rd_sel = wuf_pkg::RD_NODE_A;
          state_nxt  = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (sts.at_root) begin
          cmd.cap_a  = 1'b1;
          cmd.rd_sel = wuf_pkg::RD_NODE_B;
          state_nxt  = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        if (sts.at_root) begin
          cmd.cap_b = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.merge) begin
          cmd.wr_sel = wuf_pkg::WR_CHILD;
          state_nxt  = ST_LINK_ROOT;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_LINK_ROOT: begin
        cmd.wr_sel = wuf_pkg::WR_ROOT;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    in_stall_nxt = state_nxt != ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall_r |-> state_r == ST_IDLE)
    else $error("input ready outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_REDUCE && in_stall_r)
    else $error("accepted transaction did not start processing");

endmodule

// File: hw/rtl/weighted_union_find.sv
// ---------------------------------------------------------------------------
// weighted_union_find
// sequence: index reduction, root walk of a, root walk of b, a two-write link on a merge,
//   result load; no reduction steps at NODES >= 1024, walk length set by link depth of a/b
// throughput: one transaction at a time; depth stays at most log2(NODES), and each
//   walk step takes one memory read
// reset: a clearing pass writes every node as its own root of size one after
//   reset is released; in_stall stays high until it ends
// ---------------------------------------------------------------------------
module weighted_union_find #(
  parameter int NODES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wuf_pkg::wuf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wuf_pkg::wuf_out_t out_data
);

  // command and status between sequencer and datapath
  wuf_pkg::wuf_cmd_t cmd;
  wuf_pkg::wuf_sts_t sts;

  // sequencer: clear pass, walks of both nodes, two-write link, result hand-off
  wuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: node memory holds {tree size, parent link} per node,
  // one read per cycle with registered data feeding the next walk address
  wuf_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
